// ===== sv/whog_pkg.sv =====
// ----------------------------------------------------------------------------
// whog_pkg
// Shared types and fixed constants of the weighted history outlier gate.
// ----------------------------------------------------------------------------
package whog_pkg;

  // field widths fixed by the interface
  localparam int COORD_W    = 24;
  localparam int GATE_W     = 24;
  localparam int FILL_OUT_W = 4;

  // gate register value after reset
  localparam logic [GATE_W-1:0] GATE_RESET = 24'd400;

  // two coordinates with 8 fraction bits each: scale of whole units squared
  localparam int FRAC_SHIFT = 16;

  // squaring sequence: three partial products for x, three for y
  localparam int SQ_STEP_W = 3;
  localparam logic [SQ_STEP_W-1:0] SQ_LAST = 3'd5;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIFF,
    ST_SQR,
    ST_CMP,
    ST_WRITE
  } gate_state_t;

endpackage

// ===== sv/whog_hist_mem.sv =====
// ----------------------------------------------------------------------------
// whog_hist_mem
// History store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module whog_hist_mem #(
  parameter int DEPTH  = 10,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // store a beat of history
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // fetch one entry into the registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/whog_sq_unit.sv =====
// ----------------------------------------------------------------------------
// whog_sq_unit
// Sum of two squares, accumulated from partial products of one half-width multiplier.
// ----------------------------------------------------------------------------
module whog_sq_unit #(
  parameter int OP_W = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   op_x,
  input  logic [OP_W-1:0]   op_y,
  output logic              done,
  output logic [2*OP_W:0]   sum
);

  localparam int HW = (OP_W + 1) / 2;
  localparam int EW = 2 * OP_W + 1;

  logic                          busy;
  logic [whog_pkg::SQ_STEP_W-1:0] step;
  logic [OP_W-1:0]               sel;
  logic [2*HW-1:0]               ext;
  logic [HW-1:0]                 mul_a;
  logic [HW-1:0]                 mul_b;
  logic [2*HW-1:0]               prod;
  logic [EW-1:0]                 term;

  // pick operand and halves for this step
  always_comb begin
    sel   = (step < 3'd3) ? op_x : op_y;
    ext   = (2*HW)'(sel);
    mul_a = ext[HW-1:0];
    mul_b = ext[HW-1:0];
    term  = '0;
    prod  = mul_a * mul_b;
    unique case (step)
      3'd0, 3'd3: begin
        mul_a = ext[HW-1:0];
        mul_b = ext[HW-1:0];
        prod  = mul_a * mul_b;
        term  = EW'(prod);
      end
      3'd1, 3'd4: begin
        mul_a = ext[2*HW-1:HW];
        mul_b = ext[HW-1:0];
        prod  = mul_a * mul_b;
        term  = EW'(prod) << (HW + 1);
      end
      3'd2, 3'd5: begin
        mul_a = ext[2*HW-1:HW];
        mul_b = ext[2*HW-1:HW];
        prod  = mul_a * mul_b;
        term  = EW'(prod) << (2 * HW);
      end
      default: begin
        term = '0;
      end
    endcase
  end

  // sequence the steps, flag the final sum
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == whog_pkg::SQ_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulate partial products
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= '0;
    end else if (busy) begin
      sum <= sum + term;
    end
  end

endmodule

// ===== sv/weighted_history_outlier_gate_unit.sv =====
// Flow: with an empty history a beat goes straight to the result; otherwise the n
// stored entries are read one per cycle, the differences are squared in 6 steps,
// then compared against the gate. A new input is taken only once the previous
// result has been committed to the output register.
// Reset: synchronous, clears fill count, ring head, gate (to 400), handshake.
// ----------------------------------------------------------------------------
// weighted_history_outlier_gate_unit
// Weighted-mean outlier gate over a ring of accepted 2-D positions.
// ----------------------------------------------------------------------------
module weighted_history_outlier_gate_unit #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pos_valid,
  output logic                                pos_ready,
  input  logic signed [whog_pkg::COORD_W-1:0] position_x,
  input  logic signed [whog_pkg::COORD_W-1:0] position_y,
  input  logic                                cfg_write_en,
  input  logic [whog_pkg::GATE_W-1:0]         cfg_write_data,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                accepted,
  output logic [whog_pkg::FILL_OUT_W-1:0]     history_fill
);

  localparam int CW   = whog_pkg::COORD_W;
  localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);
  localparam int QMAX = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
  localparam int QW   = $clog2(QMAX + 1);
  localparam int SW   = CW + QW;
  localparam int DW   = SW + 1;
  localparam int ABW  = SW;
  localparam int EW   = 2 * ABW + 1;
  localparam int GPW  = whog_pkg::GATE_W + 2 * QW;
  localparam int RW   = GPW + whog_pkg::FRAC_SHIFT;
  localparam int MW   = 2 * CW;

  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);

  whog_pkg::gate_state_t state;
  whog_pkg::gate_state_t state_next;

  logic [whog_pkg::GATE_W-1:0] gate;
  logic [FW-1:0]               fill;
  logic [AW-1:0]               head;
  logic signed [CW-1:0]        px;
  logic signed [CW-1:0]        py;
  logic [FW-1:0]               issue_cnt;
  logic                        rd_pend;
  logic [FW-1:0]               rd_weight;
  logic signed [SW-1:0]        sx;
  logic signed [SW-1:0]        sy;
  logic [QW-1:0]               quan;
  logic [ABW-1:0]              dx_abs;
  logic [ABW-1:0]              dy_abs;
  logic [2*QW-1:0]             quan_sq;
  logic [RW-1:0]               rhs;
  logic                        pass;
  logic [FW-1:0]               res_fill;

  logic                        take_in;
  logic                        out_free;
  logic                        issue;
  logic                        full;
  logic                        commit;
  logic                        sq_start;
  logic                        sq_done;
  logic [EW-1:0]               sq_sum;
  logic [AW:0]                 rd_sum;
  logic [AW-1:0]               rd_addr;
  logic [AW:0]                 wr_sum;
  logic [AW-1:0]               wr_addr;
  logic [AW:0]                 head_sum;
  logic [AW-1:0]               head_inc;
  logic                        wr_en;
  logic [MW-1:0]               rd_data;
  logic signed [CW-1:0]        mem_x;
  logic signed [CW-1:0]        mem_y;
  logic signed [FW+CW:0]       prod_x;
  logic signed [FW+CW:0]       prod_y;
  logic signed [DW-1:0]        qx;
  logic signed [DW-1:0]        qy;
  logic signed [DW-1:0]        dx;
  logic signed [DW-1:0]        dy;
  logic [GPW-1:0]              gate_prod;
  logic [FW-1:0]               fill_after;

  // handshake and ring addressing
  always_comb begin
    take_in  = pos_valid && pos_ready;
    out_free = !res_valid || res_ready;
    issue    = (state == whog_pkg::ST_WALK) && (issue_cnt != fill);
    full     = (fill == DEPTH_F);
    commit   = (state == whog_pkg::ST_WRITE) && out_free;
    wr_en    = commit && pass;
    sq_start = (state == whog_pkg::ST_DIFF);

    rd_sum   = {1'b0, head} + (AW + 1)'(issue_cnt);
    rd_addr  = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : AW'(rd_sum);
    wr_sum   = {1'b0, head} + (full ? '0 : (AW + 1)'(fill));
    wr_addr  = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : AW'(wr_sum);
    head_sum = {1'b0, head} + 1'b1;
    head_inc = (head_sum >= DEPTH_A) ? AW'(head_sum - DEPTH_A) : AW'(head_sum);

    fill_after = (pass && !full) ? fill + 1'b1 : fill;
  end

  // weighted terms and scaled differences
  always_comb begin
    mem_x     = $signed(rd_data[CW-1:0]);
    mem_y     = $signed(rd_data[MW-1:CW]);
    prod_x    = $signed({1'b0, rd_weight}) * mem_x;
    prod_y    = $signed({1'b0, rd_weight}) * mem_y;
    qx        = $signed({1'b0, quan}) * px;
    qy        = $signed({1'b0, quan}) * py;
    dx        = qx - DW'(sx);
    dy        = qy - DW'(sy);
    gate_prod = GPW'(gate) * GPW'(quan_sq);
  end

  // next state and ready
  always_comb begin
    state_next = state;
    pos_ready  = (state == whog_pkg::ST_IDLE);
    unique case (state)
      whog_pkg::ST_IDLE: begin
        if (take_in) begin
          state_next = (fill == '0) ? whog_pkg::ST_WRITE : whog_pkg::ST_WALK;
        end
      end
      whog_pkg::ST_WALK: begin
        if (!issue) begin
          state_next = whog_pkg::ST_DIFF;
        end
      end
      whog_pkg::ST_DIFF: begin
        state_next = whog_pkg::ST_SQR;
      end
      whog_pkg::ST_SQR: begin
        if (sq_done) begin
          state_next = whog_pkg::ST_CMP;
        end
      end
      whog_pkg::ST_CMP: begin
        state_next = whog_pkg::ST_WRITE;
      end
      whog_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = whog_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = whog_pkg::ST_IDLE;
      end
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= whog_pkg::ST_IDLE;
      gate      <= whog_pkg::GATE_RESET;
      fill      <= '0;
      head      <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_write_en) begin
        gate <= cfg_write_data;
      end
      if (wr_en) begin
        if (full) begin
          head <= head_inc;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (commit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // walk history, form differences, compare
  always_ff @(posedge clk) begin
    rd_weight <= issue_cnt + 1'b1;
    if (take_in) begin
      px        <= position_x;
      py        <= position_y;
      sx        <= '0;
      sy        <= '0;
      quan      <= '0;
      issue_cnt <= '0;
      pass      <= 1'b1;
    end
    if (issue) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
    if (rd_pend) begin
      sx   <= sx + SW'(prod_x);
      sy   <= sy + SW'(prod_y);
      quan <= quan + QW'(rd_weight);
    end
    if (state == whog_pkg::ST_DIFF) begin
      dx_abs  <= dx[DW-1] ? ABW'(-dx) : ABW'(dx);
      dy_abs  <= dy[DW-1] ? ABW'(-dy) : ABW'(dy);
      quan_sq <= quan * quan;
    end
    if (state == whog_pkg::ST_SQR) begin
      rhs <= {gate_prod, {whog_pkg::FRAC_SHIFT{1'b0}}};
    end
    if (state == whog_pkg::ST_CMP) begin
      pass <= !(sq_sum > EW'(rhs));
    end
    if (commit) begin
      accepted <= pass;
      res_fill <= fill_after;
    end
  end

  assign history_fill = whog_pkg::FILL_OUT_W'(res_fill);

  whog_hist_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .WIDTH  (MW),
    .ADDR_W (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({py, px})
  );

  whog_sq_unit #(
    .OP_W (ABW)
  ) u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .op_x  (dx_abs),
    .op_y  (dy_abs),
    .done  (sq_done),
    .sum   (sq_sum)
  );

endmodule

// ===== sv/whog_checker.sv =====
// ----------------------------------------------------------------------------
// whog_checker
// Port-level checks of the outlier gate, bound to the top level.
// ----------------------------------------------------------------------------
module whog_checker #(
  parameter int HISTORY_DEPTH = 10
) (
  input logic        clk,
  input logic        rst,
  input logic        pos_valid,
  input logic        pos_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        accepted,
  input logic [3:0]  history_fill
);

  // hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(accepted) && $stable(history_fill))
    else $error("result beat changed while stalled");

  // drop ready in the cycle after taking a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pos_valid && pos_ready |=> !pos_ready)
    else $error("input taken while previous item in flight");

  // fill never exceeds the history depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && (HISTORY_DEPTH < 16) |-> history_fill <= 4'(HISTORY_DEPTH))
    else $error("history fill beyond depth");

  // reject only against a non-empty history
  a_reject_needs_history: assert property (@(posedge clk) disable iff (rst)
    res_valid && !accepted && (HISTORY_DEPTH < 16) |-> history_fill != 4'd0)
    else $error("rejection with empty history");

endmodule

bind weighted_history_outlier_gate_unit whog_checker #(
  .HISTORY_DEPTH (HISTORY_DEPTH)
) u_whog_checker (.*);
